// File: rtl/hsvg_pkg.sv
// ----------------------------------------------------------------------------
// HSV gradient package
// Shared constants, types and helpers for the HSV gradient interpolator.
// ----------------------------------------------------------------------------
package hsvg_pkg;

  // One 60-degree hue sector spans this many units.
  localparam int unsigned SectorBits = 16;
  localparam int unsigned SectorUnits = 65536;
  localparam int unsigned HueFull = 6 * SectorUnits;
  localparam int unsigned HueHalf = 3 * SectorUnits;
  localparam int unsigned HueBits = 19;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegStartRed   = 3'd0;
  localparam logic [2:0] RegStartGreen = 3'd1;
  localparam logic [2:0] RegStartBlue  = 3'd2;
  localparam logic [2:0] RegEndRed     = 3'd3;
  localparam logic [2:0] RegEndGreen   = 3'd4;
  localparam logic [2:0] RegEndBlue    = 3'd5;

  // Color in HSV form: hue in sector units, saturation Q16, value in channel units.
  typedef struct packed {
    logic [HueBits-1:0] hue;
    logic [16:0]        sat;
    logic [15:0]        val;
  } hsv_t;

endpackage

// File: rtl/hsvg_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel that carries a packed payload.
// ----------------------------------------------------------------------------
interface hsvg_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/hsvg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready write channel with a register index and write data.
// ----------------------------------------------------------------------------
interface hsvg_cfg_if #(
  parameter int unsigned DataWidth = 8
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           index;
  logic [DataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/hsvg_hsv_conv.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts a configured color to HSV after each register write. A shared
// restoring divider produces the saturation and hue quotients one bit a cycle.
// ----------------------------------------------------------------------------
module hsvg_hsv_conv #(
  parameter int unsigned ChannelBits = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ChannelBits-1:0] red_i,
  input  logic [ChannelBits-1:0] green_i,
  input  logic [ChannelBits-1:0] blue_i,
  output hsvg_pkg::hsv_t         hsv_o,
  output logic                   busy_o
);

  localparam int unsigned QBits = 17;
  localparam int unsigned CntBits = 5;
  localparam int unsigned FracSteps = 16;

  typedef enum logic [1:0] {
    StIdle,
    StSat,
    StHue
  } state_e;

  state_e                 state_q;
  logic [CntBits-1:0]     cnt_q;
  logic [ChannelBits-1:0] rem_q;
  logic [ChannelBits-1:0] den_q;
  logic [QBits-1:0]       quo_q;
  logic                   neg_q;
  logic [18:0]            base_q;
  logic [ChannelBits-1:0] mx_q;
  logic [ChannelBits-1:0] dlt_q;
  logic [ChannelBits-1:0] diff_abs_q;
  hsvg_pkg::hsv_t         hsv_q;

  logic [ChannelBits-1:0] mx, mn, dlt;
  logic [ChannelBits:0]   diff;
  logic [ChannelBits-1:0] diff_abs;
  logic                   dneg;
  logic [18:0]            base;
  logic                   sat_top, hue_top;
  logic [ChannelBits:0]   rem_dbl;
  logic [ChannelBits:0]   trial;
  logic                   take;
  logic signed [19:0]     hue_raw;

  // Max, min and sector base with red, then green winning ties.
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dlt = mx - mn;
    if (red_i == mx) begin
      diff = {1'b0, green_i} - {1'b0, blue_i};
      base = 19'd0;
    end else if (green_i == mx) begin
      diff = {1'b0, blue_i} - {1'b0, red_i};
      base = 19'(2 * hsvg_pkg::SectorUnits);
    end else begin
      diff = {1'b0, red_i} - {1'b0, green_i};
      base = 19'(4 * hsvg_pkg::SectorUnits);
    end
    dneg = diff[ChannelBits];
    diff_abs = dneg ? ChannelBits'(~diff + 1'b1) : diff[ChannelBits-1:0];
    // The numerator never exceeds the divisor, so the integer quotient bit
    // is set only when both are equal.
    sat_top = (dlt >= mx);
  end

  assign hue_top = (diff_abs_q >= dlt_q);

  // One restoring division step on the fraction bits.
  assign rem_dbl = {rem_q, 1'b0};
  assign take    = (rem_dbl >= {1'b0, den_q});
  assign trial   = rem_dbl - {1'b0, den_q};

  // Signed hue from the sector base, wrapped into one full turn.
  always_comb begin
    if (neg_q) hue_raw = signed'({1'b0, base_q}) - signed'({3'b000, quo_q});
    else       hue_raw = signed'({1'b0, base_q}) + signed'({3'b000, quo_q});
    if (hue_raw < 0) hue_raw = hue_raw + 20'(hsvg_pkg::HueFull);
  end

  // Sequencer: saturation quotient first, hue quotient second. A new start
  // always restarts the conversion from the current color.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      rem_q      <= '0;
      den_q      <= '0;
      quo_q      <= '0;
      neg_q      <= 1'b0;
      base_q     <= '0;
      mx_q       <= '0;
      dlt_q      <= '0;
      diff_abs_q <= '0;
      hsv_q      <= '0;
    end else if (start_i) begin
      mx_q       <= mx;
      dlt_q      <= dlt;
      base_q     <= base;
      neg_q      <= dneg;
      diff_abs_q <= diff_abs;
      if (dlt == '0) begin
        hsv_q   <= '{hue: '0, sat: '0, val: 16'(mx)};
        state_q <= StIdle;
      end else begin
        rem_q   <= sat_top ? '0 : dlt;
        den_q   <= mx;
        quo_q   <= QBits'(sat_top);
        cnt_q   <= CntBits'(FracSteps);
        state_q <= StSat;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
        end
        StSat, StHue: begin
          if (cnt_q != '0) begin
            rem_q <= take ? ChannelBits'(trial) : rem_dbl[ChannelBits-1:0];
            quo_q <= {quo_q[QBits-2:0], take};
            cnt_q <= cnt_q - 1'b1;
          end else if (state_q == StSat) begin
            hsv_q.sat <= quo_q;
            rem_q     <= hue_top ? '0 : diff_abs_q;
            den_q     <= dlt_q;
            quo_q     <= QBits'(hue_top);
            cnt_q     <= CntBits'(FracSteps);
            state_q   <= StHue;
          end else begin
            hsv_q.hue <= hue_raw[18:0];
            hsv_q.val <= 16'(mx_q);
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign hsv_o  = hsv_q;
  assign busy_o = (state_q != StIdle);

endmodule

// File: rtl/hsvg_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts positions, clamps them to [0, 1.0] and blends hue, saturation and
// value into an item for the back end queue.
// ----------------------------------------------------------------------------
module hsvg_front #(
  parameter int unsigned TFracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TFracBits+1:0] mix_t_i,
  input  hsvg_pkg::hsv_t       hsv_start_i,
  input  hsvg_pkg::hsv_t       hsv_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [18:0]          hue_o,
  output logic [16:0]          sat_o,
  output logic [16+TFracBits:0] val_o
);

  logic [TFracBits:0] t, tn;
  logic signed [19:0] dh;
  logic signed [20+TFracBits+1:0] hprod;
  logic signed [20+TFracBits+1:0] hsum;
  logic signed [20:0] hq;
  logic [18:0] hue_d;
  logic [17+TFracBits:0] s_sum;
  logic [16+TFracBits:0] v_sum;
  logic v_q;
  logic [18:0] hue_q;
  logic [16:0] sat_q;
  logic [16+TFracBits:0] val_q;

  // Clamp of the position.
  always_comb begin
    if (mix_t_i[TFracBits+1]) t = '0;
    else if (mix_t_i[TFracBits]) t = {1'b1, {TFracBits{1'b0}}};
    else t = mix_t_i[TFracBits:0];
    tn = {1'b1, {TFracBits{1'b0}}} - t;
  end

  // Shortest-arc hue blend, then saturation and value blends.
  always_comb begin
    dh = 20'(signed'({1'b0, hsv_end_i.hue})) - 20'(signed'({1'b0, hsv_start_i.hue}));
    if (dh > 20'sd196608) dh = dh - 20'sd393216;
    else if (dh < -20'sd196608) dh = dh + 20'sd393216;
    hprod = (22+TFracBits)'(signed'({1'b0, t})) * (22+TFracBits)'(dh);
    hsum  = ((22+TFracBits)'(hsv_start_i.hue) <<< TFracBits) + hprod;
    hq    = 21'(hsum >>> TFracBits);
    if (hq < 0) hue_d = 19'(hq + 21'sd393216);
    else if (hq >= 21'sd393216) hue_d = 19'(hq - 21'sd393216);
    else hue_d = 19'(hq);
    s_sum = (18+TFracBits)'(hsv_start_i.sat) * (18+TFracBits)'(tn)
          + (18+TFracBits)'(hsv_end_i.sat) * (18+TFracBits)'(t);
    v_sum = (17+TFracBits)'(hsv_start_i.val) * (17+TFracBits)'(tn)
          + (17+TFracBits)'(hsv_end_i.val) * (17+TFracBits)'(t);
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hue_q <= hue_d;
      sat_q <= 17'(s_sum >> TFracBits);
      val_q <= v_sum;
    end
  end

  assign out_valid_o = v_q;
  assign hue_o = hue_q;
  assign sat_o = sat_q;
  assign val_o = val_q;

endmodule

// File: rtl/hsvg_back.sv
// ----------------------------------------------------------------------------
// Back end
// Two-entry queue followed by the HSV to RGB conversion pipeline: one stage
// forms the sector factors, one stage scales the value and saturates.
// ----------------------------------------------------------------------------
module hsvg_back #(
  parameter int unsigned ChannelBits = 8,
  parameter int unsigned TFracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [18:0]            hue_i,
  input  logic [16:0]            sat_i,
  input  logic [16+TFracBits:0]  val_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3*ChannelBits-1:0] rgb_o
);

  localparam int unsigned VBits = 17 + TFracBits;
  localparam int unsigned PBits = VBits + 17;
  localparam logic [ChannelBits-1:0] ChanMax = '1;

  // Queue storage.
  logic [VBits+35:0] fifo_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;
  logic              pop;
  logic [VBits+35:0] head;

  // Pipeline stages.
  logic              s1_v_q, s2_v_q;
  logic [16:0]       fr_q, fg_q, fb_q;
  logic [VBits-1:0]  v1_q;
  logic [3*ChannelBits-1:0] rgb_q;
  logic              s1_en, s2_en;

  logic [15:0] f;
  logic [16:0] fo, fp, fq, fr, fg, fb;
  logic [32:0] sp, sq;
  logic [ChannelBits-1:0] cr, cg, cb;

  assign in_ready_o = (cnt_q != 2'd2);
  assign head = fifo_q[rd_q];
  assign s2_en = !s2_v_q || out_ready_i;
  assign s1_en = !s1_v_q || s2_en;
  assign pop = (cnt_q != 2'd0) && s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(pop);
      if (s1_en) s1_v_q <= pop;
      if (s2_en) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) fifo_q[wr_q] <= {hue_i, sat_i, val_i};
  end

  // Sector factors.
  always_comb begin
    logic [18:0] h;
    logic [16:0] s;
    h  = head[VBits+35:VBits+17];
    s  = head[VBits+16:VBits];
    f  = h[15:0];
    sp = 33'(s) * 33'(f);
    sq = 33'(s) * 33'(17'h10000 - 17'(f));
    fo = 17'h10000 - s;
    fp = 17'h10000 - 17'(sp >> 16);
    fq = 17'h10000 - 17'(sq >> 16);
    if (s == '0) begin
      fr = 17'h10000; fg = 17'h10000; fb = 17'h10000;
    end else begin
      unique case (h[18:16])
        3'd0: begin fr = 17'h10000; fg = fq; fb = fo; end
        3'd1: begin fr = fp; fg = 17'h10000; fb = fo; end
        3'd2: begin fr = fo; fg = 17'h10000; fb = fq; end
        3'd3: begin fr = fo; fg = fp; fb = 17'h10000; end
        3'd4: begin fr = fq; fg = fo; fb = 17'h10000; end
        default: begin fr = 17'h10000; fg = fo; fb = fp; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && pop) begin
      fr_q <= fr;
      fg_q <= fg;
      fb_q <= fb;
      v1_q <= head[VBits-1:0];
    end
  end

  // Scaling with round half up and saturation.
  function automatic logic [ChannelBits-1:0] scale(input logic [VBits-1:0] v,
                                                   input logic [16:0] fac);
    logic [PBits-1:0] p;
    logic [PBits-1:0] c;
    p = PBits'(v) * PBits'(fac) + (PBits'(1) << (TFracBits + 15));
    c = p >> (TFracBits + 16);
    if (c > PBits'(ChanMax)) return ChanMax;
    return ChannelBits'(c);
  endfunction

  assign cr = scale(v1_q, fr_q);
  assign cg = scale(v1_q, fg_q);
  assign cb = scale(v1_q, fb_q);

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) rgb_q <= {cr, cg, cb};
  end

  assign out_valid_o = s2_v_q;
  assign rgb_o = rgb_q;

endmodule

// File: rtl/hsv_color_gradient_interpolator_unit.sv
// ----------------------------------------------------------------------------
// HSV color gradient interpolator
// Blends two configured RGB colors in HSV space by a clamped position.
// ----------------------------------------------------------------------------
// One position is taken every clock unless positions are held off or the
// output stalls. A front stage clamps the position and blends hue (shorter
// arc), saturation and value, a two-entry queue decouples it from the back
// end, and two back stages form the sector factors and scale them. Each write
// to a color register restarts a bit-serial HSV conversion of both colors;
// positions are held off while any configuration transfer is offered, in the
// start cycle and through both 16-step divisions and their wrap-up steps.
module hsv_color_gradient_interpolator_unit #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvg_cfg_if.sink    cfg,
  hsvg_stream_if.sink in_ch,
  hsvg_stream_if.source out_ch
);

  logic [CHANNEL_BITS-1:0] regs_q [6];
  logic                    conv_start_q;
  logic                    busy_s, busy_e;
  logic                    hold;
  hsvg_pkg::hsv_t          hsv_s, hsv_e;
  logic                    f_valid, f_ready;
  logic [18:0]             f_hue;
  logic [16:0]             f_sat;
  logic [16+T_FRAC_BITS:0] f_val;

  assign cfg.ready = 1'b1;

  // Color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= '0;
      regs_q[1] <= '0;
      regs_q[2] <= '0;
      regs_q[3] <= '1;
      regs_q[4] <= '1;
      regs_q[5] <= '1;
      conv_start_q <= 1'b1;
    end else begin
      conv_start_q <= cfg.valid && (cfg.index <= hsvg_pkg::RegEndBlue);
      if (cfg.valid && (cfg.index <= hsvg_pkg::RegEndBlue)) begin
        regs_q[cfg.index] <= cfg.data[CHANNEL_BITS-1:0];
      end
    end
  end

  hsvg_hsv_conv #(.ChannelBits(CHANNEL_BITS)) u_conv_s (
    .clk_i, .rst_ni, .start_i(conv_start_q),
    .red_i(regs_q[0]), .green_i(regs_q[1]), .blue_i(regs_q[2]),
    .hsv_o(hsv_s), .busy_o(busy_s)
  );

  hsvg_hsv_conv #(.ChannelBits(CHANNEL_BITS)) u_conv_e (
    .clk_i, .rst_ni, .start_i(conv_start_q),
    .red_i(regs_q[3]), .green_i(regs_q[4]), .blue_i(regs_q[5]),
    .hsv_o(hsv_e), .busy_o(busy_e)
  );

  // Positions wait while a configuration write or a color conversion is pending.
  assign hold = cfg.valid || conv_start_q || busy_s || busy_e;

  logic in_rdy;
  hsvg_front #(.TFracBits(T_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid && !hold), .in_ready_o(in_rdy),
    .mix_t_i(in_ch.data), .hsv_start_i(hsv_s), .hsv_end_i(hsv_e),
    .out_valid_o(f_valid), .out_ready_i(f_ready),
    .hue_o(f_hue), .sat_o(f_sat), .val_o(f_val)
  );
  assign in_ch.ready = in_rdy && !hold;

  hsvg_back #(.ChannelBits(CHANNEL_BITS), .TFracBits(T_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready),
    .hue_i(f_hue), .sat_i(f_sat), .val_i(f_val),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .rgb_o(out_ch.data)
  );

endmodule
